// File: rtl/core/smh_pkg.sv
// smh_pkg: types, constants and round functions for the sha-256 message hasher
// no dependencies; imported by sha256_message_hasher and its testbench
`default_nettype none

package smh_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } smh_state_t;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sha256_message_hasher.sv
// sha256_message_hasher: byte-serial sha-256 with in-block padding and digest readout
// depends on smh_pkg (state type, round constants, initial hash, round functions)
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | to block  | in_valid / in_stall  | msg_byte, byte_present, end_of_message
//  out     | from block| out_valid / out_stall| digest_word, word_number, last_word
//
//  a word without end of message is taken while idle; a byte that completes a 64-byte block
//  starts 64 rounds and then a fold of the result into the chaining words
//  the end-of-message word shifts in padding one byte per cycle outside compression (up to 64,
//  or up to 72 with a second block); each block is compressed, then 8 digest words follow
//  the single round unit (one sha-256 round per cycle) sets the block rate
//  rst_n clears the control state and loads the initial hash; in_stall is high from the
//  first busy cycle until the last digest word is taken, and out_stall only holds readout

module sha256_message_hasher
    import smh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_number,
    output logic             last_word
);

    smh_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;        // bytes waiting in the block
    logic [63:0] bits_reg, bits_next;        // message length in bits, wraps
    logic [5:0]  round_reg, round_next;
    logic [2:0]  wcnt_reg, wcnt_next;        // digest word being shown
    logic        fin_reg, fin_next;          // end of message seen, padding under way
    logic        mark_reg, mark_next;        // 0x80 already shifted in
    logic        lblk_reg, lblk_next;        // current block carries the length
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] work_reg [8];               // a..h
    logic [31:0] work_next [8];
    logic [31:0] sched_reg [16];             // block words, then schedule window
    logic [31:0] sched_next [16];

    logic [31:0] sched_byte [16];
    logic [31:0] sched_round [16];
    logic [7:0]  byte_in;
    logic [7:0]  pad_byte;
    logic [2:0]  len_sel;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    // next padding byte: mark, then zeros, then the big-endian length in the final block
    always_comb
    begin
        len_sel = LAST_WORD - fill_reg[2:0];
        if (!mark_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (lblk_reg && (fill_reg >= LENGTH_POS))
        begin
            pad_byte = bits_reg[{len_sel, 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
        byte_in = (state_reg == ST_PAD) ? pad_byte : msg_byte;
    end

    // bytes enter at the low end, so after 64 of them word 0 holds bytes 0..3
    always_comb
    begin
        for (int i = 0; i < 15; i++)
        begin
            sched_byte[i] = {sched_reg[i][23:0], sched_reg[i+1][31:24]};
        end
        sched_byte[15] = {sched_reg[15][23:0], byte_in};
    end

    // round datapath: word for this round sits in slot 0
    always_comb
    begin
        w_new = sml_sig1(sched_reg[14]) + sched_reg[9] + sml_sig0(sched_reg[1]) + sched_reg[0];
        for (int i = 0; i < 15; i++)
        begin
            sched_round[i] = sched_reg[i+1];
        end
        sched_round[15] = w_new;
        t1 = work_reg[7] + big_sig1(work_reg[4]) + choose(work_reg[4], work_reg[5], work_reg[6])
             + ROUND_K[round_reg] + sched_reg[0];
        t2 = big_sig0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        wcnt_next  = wcnt_reg;
        fin_next   = fin_reg;
        mark_next  = mark_reg;
        lblk_next  = lblk_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        sched_next = sched_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        sched_next = sched_byte;
                        fill_next  = fill_reg + 6'd1;
                        bits_next  = bits_reg + 64'd8;
                    end
                    if (end_of_message)
                    begin
                        fin_next = 1'b1;
                    end
                    if (byte_present && (fill_reg == LAST_BYTE))
                    begin
                        state_next = ST_ROUND;
                        work_next  = chain_reg;
                        round_next = '0;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                sched_next = sched_byte;
                fill_next  = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next = 1'b1;
                    lblk_next = (fill_reg < LENGTH_POS);
                end
                if (fill_reg == LAST_BYTE)
                begin
                    state_next = ST_ROUND;
                    work_next  = chain_reg;
                    round_next = '0;
                end
            end

            ST_ROUND:
            begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                sched_next   = sched_round;
                round_next   = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (mark_reg && lblk_reg)
                begin
                    state_next = ST_EMIT;
                    wcnt_next  = '0;
                end
                else
                begin
                    // mark already in a block too full for the length: next block holds it
                    if (mark_reg)
                    begin
                        lblk_next = 1'b1;
                    end
                    state_next = ST_PAD;
                end
            end

            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    wcnt_next = wcnt_reg + 3'd1;
                    if (wcnt_reg == LAST_WORD)
                    begin
                        state_next = ST_IDLE;
                        chain_next = INIT_HASH;
                        bits_next  = '0;
                        fin_next   = 1'b0;
                        mark_next  = 1'b0;
                        lblk_next  = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            wcnt_reg  <= '0;
            fin_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lblk_reg  <= 1'b0;
            chain_reg <= INIT_HASH;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            round_reg <= round_next;
            wcnt_reg  <= wcnt_next;
            fin_reg   <= fin_next;
            mark_reg  <= mark_next;
            lblk_reg  <= lblk_next;
            chain_reg <= chain_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = chain_reg[wcnt_reg];
    assign word_number = wcnt_reg;
    assign last_word   = (wcnt_reg == LAST_WORD);

    // compression only ever runs on a complete block
    a_round_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (fill_reg == '0))
        else $error("compression started with a partial block");

    a_round_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (round_reg != LAST_ROUND)
        |=> (state_reg == ST_ROUND) && (round_reg == $past(round_reg) + 6'd1))
        else $error("round counter skipped or compression left early");

    a_last_round_folds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (round_reg == LAST_ROUND) |=> (state_reg == ST_FOLD))
        else $error("last round not followed by fold");

    a_restart_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word
        |=> (state_reg == ST_IDLE) && (bits_reg == '0) && (fill_reg == '0)
            && (chain_reg[0] == INIT_HASH[0]) && !fin_reg)
        else $error("hasher not reinitialized after last digest word");

endmodule

`default_nettype wire

// File: dv/sha256_message_hasher_tb.sv
// sha256_message_hasher_tb: self-checking bench for the byte-serial sha-256 hasher
// drives message words, predicts digests with its own sha-256 and checks each digest word
// depends on smh_pkg (round constants, initial hash, padding constants) and the rtl top
`default_nettype none

module sha256_message_hasher_tb;
    import smh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected digest word as it should leave the block
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  position;
        logic        tail;
    } digest_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] msg_byte = 8'h00;
    logic       byte_present = 1'b0;
    logic       end_of_message = 1'b0;

    // output channel
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    // predicted hasher state
    logic [31:0] hash_chain [8];
    logic [7:0]  byte_buf [64];
    logic [5:0]  fill_level;
    logic [63:0] bit_total;

    // digest words still owed by the block, oldest first
    digest_t digest_q [$];

    // idling controls, switched per test and per message
    bit src_idle = 1'b0;
    bit sink_idle = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned checked_words = 0;
    int unsigned msg_count = 0;
    int unsigned byte_count = 0;
    int unsigned sink_hold = 0;
    digest_t oldest;

    sha256_message_hasher u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .msg_byte       (msg_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_number    (word_number),
        .last_word      (last_word)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // right rotate by doubling the word and shifting
    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    // back to the initial hash with an empty buffer and zero bit count
    task automatic restart_chain();
        hash_chain = INIT_HASH;
        fill_level = '0;
        bit_total = '0;
    endtask

    // full 64-round compression of byte_buf into hash_chain
    task automatic compress_buf();
        logic [31:0] sched [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
        int r;
        for (r = 0; r < 16; r++)
        begin
            sched[r] = {byte_buf[4*r], byte_buf[4*r+1], byte_buf[4*r+2], byte_buf[4*r+3]};
        end
        for (r = 16; r < 64; r++)
        begin
            sched[r] = (ror32(sched[r-2], 17) ^ ror32(sched[r-2], 19) ^ (sched[r-2] >> 10))
                     + sched[r-7]
                     + (ror32(sched[r-15], 7) ^ ror32(sched[r-15], 18) ^ (sched[r-15] >> 3))
                     + sched[r-16];
        end
        va = hash_chain[0];
        vb = hash_chain[1];
        vc = hash_chain[2];
        vd = hash_chain[3];
        ve = hash_chain[4];
        vf = hash_chain[5];
        vg = hash_chain[6];
        vh = hash_chain[7];
        for (r = 0; r < 64; r++)
        begin
            t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
               + ((ve & vf) ^ (~ve & vg)) + ROUND_K[r] + sched[r];
            t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
               + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg;
            vg = vf;
            vf = ve;
            ve = vd + t1;
            vd = vc;
            vc = vb;
            vb = va;
            va = t1 + t2;
        end
        hash_chain[0] += va;
        hash_chain[1] += vb;
        hash_chain[2] += vc;
        hash_chain[3] += vd;
        hash_chain[4] += ve;
        hash_chain[5] += vf;
        hash_chain[6] += vg;
        hash_chain[7] += vh;
    endtask

    // advance the predicted state by one accepted word and queue any digest
    task automatic predict_digest(input logic [7:0] b, input logic has_byte, input logic ends);
        int i;
        digest_t entry;
        if (has_byte)
        begin
            byte_buf[fill_level] = b;
            fill_level++;
            bit_total += 64'd8;
            byte_count++;
            // a byte that fills the block compresses it at once
            if (fill_level == '0)
                compress_buf();
        end
        if (ends)
        begin
            byte_buf[fill_level] = PAD_MARK;
            for (i = fill_level + 1; i < 64; i++)
                byte_buf[i] = 8'h00;
            // no room for the length: flush this block and pad a fresh one
            if (fill_level >= LENGTH_POS)
            begin
                compress_buf();
                for (i = 0; i < LENGTH_POS; i++)
                    byte_buf[i] = 8'h00;
            end
            for (i = 0; i < 8; i++)
                byte_buf[LENGTH_POS + i] = bit_total[63 - 8*i -: 8];
            compress_buf();
            for (i = 0; i < 8; i++)
            begin
                entry.value    = hash_chain[i];
                entry.position = 3'(i);
                entry.tail     = (3'(i) == LAST_WORD);
                digest_q       = {digest_q, entry};
            end
            restart_chain();
        end
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // present one word and wait for it to be taken; valid stays high afterwards so that
    // a following word can be presented in the same step, callers that wait drop it first
    task automatic send_word(input logic [7:0] b, input logic has_byte, input logic ends);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        msg_byte       <= b;
        byte_present   <= has_byte;
        end_of_message <= ends;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digest(b, has_byte, ends);
    endtask

    // stop offering words and hold until every owed digest word has arrived
    task automatic wait_for_digests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // one message of random bytes; the end mark rides on the last byte or comes alone
    task automatic send_message(input int unsigned len, input bit end_on_byte,
                                input bit with_noise);
        int unsigned k;
        for (k = 0; k < len; k++)
        begin
            // stray words with neither byte nor end must leave the block unchanged
            if (with_noise && $urandom_range(0, 9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!(end_on_byte && len != 0))
            send_word(8'($urandom), 1'b0, 1'b1);
        msg_count++;
    endtask

    // ------------------------------------------------------------------
    // output side: random stall after each taken word, then compare with the oldest
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("digest word %08h with no digest pending", digest_word);
                    mismatch_count++;
                end
                else
                begin
                    oldest = digest_q.pop_front();
                    checked_words++;
                    if (digest_word !== oldest.value)
                    begin
                        $error("digest_word expected %08h actual %08h", oldest.value,
                               digest_word);
                        mismatch_count++;
                    end
                    if (word_number !== oldest.position)
                    begin
                        $error("word_number expected %0d actual %0d", oldest.position,
                               word_number);
                        mismatch_count++;
                    end
                    if (last_word !== oldest.tail)
                    begin
                        $error("last_word expected %0b actual %0b", oldest.tail, last_word);
                        mismatch_count++;
                    end
                end
                sink_hold = sink_idle ? $urandom_range(0, 3) : 0;
                if (sink_hold != 0)
                    out_stall <= 1'b1;
            end
            else if (sink_hold != 0)
            begin
                sink_hold--;
                if (sink_hold == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty messages, single extreme bytes, the classic three-byte message, stray words
    task automatic test_short_messages();
        // back to back with no idling on either side
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_word(8'h00, 1'b0, 1'b1);       // empty message
        send_word(8'hff, 1'b0, 1'b0);       // stray word, ignored
        send_word(8'hff, 1'b0, 1'b1);       // empty again, byte field must be ignored
        send_word(8'h00, 1'b1, 1'b1);       // one zero byte with the end mark
        send_word(8'hff, 1'b1, 1'b1);       // one all-ones byte with the end mark
        msg_count += 4;
        // from here on both sides idle at random
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1);       // end alone after one byte
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b1);
        msg_count += 3;
    endtask

    // padding that spills into a second block and a byte that fills the block;
    // the sender holds off until each digest is out before the next message
    task automatic test_block_edges();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_message(56, 1'b0, 1'b0);       // pad spills into a second block
        wait_for_digests();
        send_message(64, 1'b1, 1'b0);       // filling byte carries the end mark
        wait_for_digests();
    endtask

    // random short messages with stray words in between
    task automatic test_random_messages(input int unsigned word_budget);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < word_budget)
        begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                wait_for_digests();
            len = $urandom_range(0, 12);
            send_message(len, $urandom_range(0, 1), 1'b1);
            sent += len + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        restart_chain();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_messages();
        test_block_edges();
        test_random_messages(20);

        // drain, then allow for a full two-block pad pass in flight
        wait_for_digests();
        repeat (300) @(posedge clk);

        $display("hashed %0d messages (%0d bytes), %0d digest words checked", msg_count,
                 byte_count, checked_words);
        $display("lengths covered: empty, single byte, padding overflow, full-block ends");
        if (mismatch_count == 0 && digest_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
